>>> rtl/core/eff_pkg.sv
// eff_pkg: shared types and constants for the escaped field framer fifo
// word layouts, command and status codes, separators, register reset values
// no dependencies
package eff_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam logic [1:0] CMD_FIELD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_START_FIELD = 2'd1;
    localparam logic [1:0] CMD_END_ROW     = 2'd2;
    localparam logic [1:0] CMD_READ        = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [7:0] SEP_COMMA   = 8'h2C;
    localparam logic [7:0] SEP_NEWLINE = 8'h0A;
    localparam logic [7:0] SEP_HASH    = 8'h23;

    localparam logic [7:0] CFG_IDX_ESCAPE = 8'd0;
    localparam logic [7:0] CFG_IDX_MASK   = 8'd1;

    localparam logic [7:0] ESCAPE_RESET = 8'd27;
    localparam logic [7:0] MASK_RESET   = 8'd32;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_byte;
        logic       out_valid;
        logic [7:0] free_count;
    } t_out_word;

endpackage

>>> rtl/core/eff_ram.sv
// eff_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module eff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/escaped_field_framer_fifo_unit.sv
// escaped_field_framer_fifo_unit: byte-stuffing field framer into a ring buffer, on eff_pkg, eff_ram
// the result word is registered and appears in the cycle after the input word is accepted
// throughput: one word per cycle while the result side is ready; after an escaped field
// byte the unit is busy and takes no word while its second byte goes through the single write port of the ring ram
// reset: synchronous active low; indices cleared, row-start set, registers to
// defaults; ram contents are not cleared, no clearing pass
module escaped_field_framer_fifo_unit #(
    parameter int DEPTH = eff_pkg::DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  eff_pkg::t_in_word   i_in_word,
    output logic                o_valid,
    input  logic                i_ready,
    output eff_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] r_write_index, n_write_index;
    logic [AW-1:0] r_read_index, n_read_index;
    logic [AW-1:0] r_free, n_free;
    logic          r_at_row_start, n_at_row_start;
    logic          r_busy, n_busy;
    logic [7:0]    r_second;
    logic [7:0]    n_second;
    logic [7:0]    r_escape;
    logic [7:0]    r_mask;

    logic          r_o_valid;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_pop;
    logic          n_pop;
    logic [7:0]    r_free_count;
    logic [7:0]    n_free_count;

    logic          accept;
    logic          is_esc;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] wi_inc;
    logic [AW-1:0] ri_inc;
    logic [AW+7:0] free_ext;

    assign o_ready     = !r_busy && (!r_o_valid || i_ready);
    assign accept      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign wi_inc = (r_write_index == LAST_IDX) ? '0 : r_write_index + AW'(1);
    assign ri_inc = (r_read_index == LAST_IDX) ? '0 : r_read_index + AW'(1);

    assign is_esc = (i_in_word.data_byte == eff_pkg::SEP_COMMA)
                 || (i_in_word.data_byte == eff_pkg::SEP_NEWLINE)
                 || (i_in_word.data_byte == eff_pkg::SEP_HASH)
                 || (i_in_word.data_byte == r_escape);

    always_comb begin
        n_write_index  = r_write_index;
        n_read_index   = r_read_index;
        n_free         = r_free;
        n_at_row_start = r_at_row_start;
        n_busy         = 1'b0;
        n_second       = r_second;
        n_status       = eff_pkg::STATUS_OK;
        n_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = r_write_index;
        ram_wdata      = r_second;
        ram_re         = 1'b0;

        if (r_busy) begin
            // second byte of an escaped pair
            ram_we        = 1'b1;
            n_write_index = wi_inc;
        end else if (accept) begin
            case (i_in_word.command)
                eff_pkg::CMD_FIELD_BYTE: begin
                    if (is_esc && (r_free < AW'(2))) begin
                        n_status = eff_pkg::STATUS_FULL;
                    end else if (!is_esc && (r_free == '0)) begin
                        n_status = eff_pkg::STATUS_FULL;
                    end else if (is_esc) begin
                        ram_we        = 1'b1;
                        ram_wdata     = r_escape;
                        n_write_index = wi_inc;
                        n_second      = i_in_word.data_byte ^ r_mask;
                        n_busy        = 1'b1;
                        n_free        = r_free - AW'(2);
                    end else begin
                        ram_we        = 1'b1;
                        ram_wdata     = i_in_word.data_byte;
                        n_write_index = wi_inc;
                        n_free        = r_free - AW'(1);
                    end
                end
                eff_pkg::CMD_START_FIELD: begin
                    if (r_at_row_start) begin
                        n_at_row_start = 1'b0;
                    end else if (r_free == '0) begin
                        n_status = eff_pkg::STATUS_FULL;
                    end else begin
                        ram_we        = 1'b1;
                        ram_wdata     = eff_pkg::SEP_COMMA;
                        n_write_index = wi_inc;
                        n_free        = r_free - AW'(1);
                    end
                end
                eff_pkg::CMD_END_ROW: begin
                    if (r_free == '0) begin
                        n_status = eff_pkg::STATUS_FULL;
                    end else begin
                        ram_we         = 1'b1;
                        ram_wdata      = eff_pkg::SEP_NEWLINE;
                        n_write_index  = wi_inc;
                        n_free         = r_free - AW'(1);
                        n_at_row_start = 1'b1;
                    end
                end
                default: begin
                    if (r_read_index == r_write_index) begin
                        n_status = eff_pkg::STATUS_EMPTY;
                    end else begin
                        ram_re       = 1'b1;
                        n_pop        = 1'b1;
                        n_read_index = ri_inc;
                        n_free       = r_free + AW'(1);
                    end
                end
            endcase
        end
    end

    // free count saturates at 255 for deep buffers
    assign free_ext     = {8'b0, n_free};
    assign n_free_count = (free_ext > (AW + 8)'(255)) ? 8'hFF : free_ext[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index  <= '0;
            r_read_index   <= '0;
            r_free         <= LAST_IDX;
            r_at_row_start <= 1'b1;
            r_busy         <= 1'b0;
            r_escape       <= eff_pkg::ESCAPE_RESET;
            r_mask         <= eff_pkg::MASK_RESET;
            r_o_valid      <= 1'b0;
        end else begin
            r_write_index  <= n_write_index;
            r_read_index   <= n_read_index;
            r_free         <= n_free;
            r_at_row_start <= n_at_row_start;
            r_busy         <= n_busy;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    eff_pkg::CFG_IDX_ESCAPE: r_escape <= i_cfg_data;
                    eff_pkg::CFG_IDX_MASK:   r_mask   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_second <= n_second;
        if (accept) begin
            r_status     <= n_status;
            r_pop        <= n_pop;
            r_free_count <= n_free_count;
        end
    end

    // popped byte comes straight from the ram read register, held until the next read
    eff_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_read_index),
        .o_rdata (ram_rdata)
    );

    assign o_valid               = r_o_valid;
    assign o_out_word.status     = r_status;
    assign o_out_word.out_byte   = r_pop ? ram_rdata : 8'h00;
    assign o_out_word.out_valid  = r_pop;
    assign o_out_word.free_count = r_free_count;

endmodule

>>> test/eff_result_checker.sv
// eff_result_checker: watches the framer's word, result and register channels,
// predicts every result word and compares it with what the unit returns
// depends on eff_pkg
`timescale 1ns / 100ps

module eff_result_checker #(
    parameter int DEPTH = eff_pkg::DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  eff_pkg::t_in_word   i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  eff_pkg::t_out_word  i_out_word,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import eff_pkg::*;

    logic [7:0] ring_mem [DEPTH];
    int         wr_ptr;
    int         rd_ptr;
    logic       row_start;
    logic [7:0] esc_reg;
    logic [7:0] mask_reg;
    int         fail_cnt = 0;
    t_out_word  predicted_words [$];

    assign o_fail_count = fail_cnt;
    assign o_pending    = predicted_words.size();

    function automatic int free_slots();
        return DEPTH - 1 - ((wr_ptr + DEPTH - rd_ptr) % DEPTH);
    endfunction

    function automatic void store_byte(logic [7:0] b);
        ring_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % DEPTH;
    endfunction

    // advances the framer state by one word and returns the result word it gives
    function automatic t_out_word frame_word(t_in_word w);
        t_out_word r;
        logic      needs_esc;
        int        fc;
        r = '0;
        r.status = STATUS_OK;
        case (w.command)
            CMD_FIELD_BYTE: begin
                needs_esc = (w.data_byte == SEP_COMMA) || (w.data_byte == SEP_NEWLINE) ||
                            (w.data_byte == SEP_HASH) || (w.data_byte == esc_reg);
                if (free_slots() < (needs_esc ? 2 : 1)) begin
                    r.status = STATUS_FULL;
                end else if (needs_esc) begin
                    store_byte(esc_reg);
                    store_byte(w.data_byte ^ mask_reg);
                end else begin
                    store_byte(w.data_byte);
                end
            end
            CMD_START_FIELD: begin
                // first field of a row writes no comma, so it never sees full
                if (row_start) begin
                    row_start = 1'b0;
                end else if (free_slots() < 1) begin
                    r.status = STATUS_FULL;
                end else begin
                    store_byte(SEP_COMMA);
                end
            end
            CMD_END_ROW: begin
                if (free_slots() < 1) begin
                    r.status = STATUS_FULL;
                end else begin
                    store_byte(SEP_NEWLINE);
                    row_start = 1'b1;
                end
            end
            default: begin
                if (rd_ptr == wr_ptr) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.out_byte  = ring_mem[rd_ptr];
                    r.out_valid = 1'b1;
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                end
            end
        endcase
        fc = free_slots();
        r.free_count = (fc > 255) ? 8'd255 : fc[7:0];
        return r;
    endfunction

    function automatic void note_mismatch(string what, int exp_v, int act_v);
        if (fail_cnt < 10) begin
            $display("%0t: result %s mismatch, expected %0d, got %0d",
                     $realtime, what, exp_v, act_v);
        end
        fail_cnt++;
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            wr_ptr    = 0;
            rd_ptr    = 0;
            row_start = 1'b1;
            esc_reg   = ESCAPE_RESET;
            mask_reg  = MASK_RESET;
            predicted_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_ESCAPE) begin
                    esc_reg = i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_MASK) begin
                    mask_reg = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_words.size() == 0) begin
                    if (fail_cnt < 10) begin
                        $display("%0t: result word %h with none outstanding",
                                 $realtime, i_out_word);
                    end
                    fail_cnt++;
                end else begin
                    exp_w = predicted_words.pop_front();
                    if (i_out_word.status !== exp_w.status)
                        note_mismatch("status", exp_w.status, i_out_word.status);
                    if (i_out_word.out_byte !== exp_w.out_byte)
                        note_mismatch("out_byte", exp_w.out_byte, i_out_word.out_byte);
                    if (i_out_word.out_valid !== exp_w.out_valid)
                        note_mismatch("out_valid", exp_w.out_valid, i_out_word.out_valid);
                    if (i_out_word.free_count !== exp_w.free_count)
                        note_mismatch("free_count", exp_w.free_count, i_out_word.free_count);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_words.push_back(frame_word(i_in_word));
            end
        end
    end

endmodule

>>> test/tb.sv
// tb: stimulus and verdict for escaped_field_framer_fifo_unit
// drives field, row and read words under several register settings with random stalls
// depends on eff_pkg, the unit and eff_result_checker
`timescale 1ns / 100ps

module tb;
    import eff_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_word   i_in_word = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    int         fail_count;
    int         pending;
    int         words_sent = 0;
    int         stall_left = 0;
    logic       steady_tx = 1'b0;
    logic       steady_rx = 1'b0;
    logic [7:0] cur_escape = ESCAPE_RESET;

    always #5 i_clk = ~i_clk;

    escaped_field_framer_fifo_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_word   (i_in_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    eff_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_word   (o_out_word),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_field_byte();
        case ($urandom_range(0, 9))
            0:       return SEP_COMMA;
            1:       return SEP_NEWLINE;
            2:       return SEP_HASH;
            3:       return cur_escape;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if (!steady_rx && $urandom_range(0, 5) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [7:0] b);
        i_valid             <= 1'b1;
        i_in_word.command   <= cmd;
        i_in_word.data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        if (!steady_tx && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // hold off until every outstanding result word has come back
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_IDX_ESCAPE)
            cur_escape = value;
    endtask

    task automatic send_row(logic filling);
        int n_fields;
        n_fields = $urandom_range(1, 5);
        repeat (n_fields) begin
            send_word(CMD_START_FIELD, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 8)) begin
                send_word(CMD_FIELD_BYTE, pick_field_byte());
                if (!filling && $urandom_range(0, 3) == 0)
                    send_word(CMD_READ, 8'($urandom_range(0, 255)));
            end
        end
        // rows left open exercise a comma right after another row's fields
        if ($urandom_range(0, 9) != 0)
            send_word(CMD_END_ROW, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(int n_words, logic pause_midway);
        int    stop_at;
        int    pause_at;
        int    kind;
        logic  filling;
        stop_at   = words_sent + n_words;
        pause_at  = words_sent + n_words / 2;
        steady_tx = ($urandom_range(0, 3) == 0);
        steady_rx = ($urandom_range(0, 3) == 0);
        while (words_sent < stop_at) begin
            // alternate windows that push the ring to full and pull it to empty
            filling = ((words_sent / 200) % 2) == 0;
            kind    = $urandom_range(0, 9);
            if (pause_midway && words_sent >= pause_at) begin
                pause_midway = 1'b0;
                wait_idle();
            end
            if (kind < (filling ? 7 : 3)) begin
                send_row(filling);
            end else if (kind < 9) begin
                repeat (filling ? $urandom_range(1, 3) : $urandom_range(20, 80))
                    send_word(CMD_READ, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 12))
                    send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty read, first field, every escaped byte, comma and newline
        send_word(CMD_READ, 8'hFF);
        send_word(CMD_START_FIELD, 8'h00);
        send_word(CMD_FIELD_BYTE, 8'h00);
        send_word(CMD_FIELD_BYTE, 8'hFF);
        send_word(CMD_FIELD_BYTE, SEP_COMMA);
        send_word(CMD_FIELD_BYTE, SEP_NEWLINE);
        send_word(CMD_FIELD_BYTE, SEP_HASH);
        send_word(CMD_FIELD_BYTE, ESCAPE_RESET);
        send_word(CMD_FIELD_BYTE, MASK_RESET);
        send_word(CMD_START_FIELD, 8'hFF);
        send_word(CMD_FIELD_BYTE, 8'h41);
        send_word(CMD_END_ROW, 8'hAA);
        send_word(CMD_START_FIELD, 8'h55);
        send_word(CMD_END_ROW, 8'h00);
        repeat (10) send_word(CMD_READ, 8'h5A);
        wait_idle();

        run_phase(270, 1'b1);
        write_reg(CFG_IDX_ESCAPE, 8'h00);
        write_reg(CFG_IDX_MASK, 8'h00);
        run_phase(270, 1'b0);
        write_reg(CFG_IDX_ESCAPE, 8'hFF);
        write_reg(CFG_IDX_MASK, 8'hFF);
        run_phase(270, 1'b0);
        // escape byte equal to a separator, plus writes to unused indexes
        write_reg(CFG_IDX_ESCAPE, SEP_COMMA);
        write_reg(CFG_IDX_MASK, 8'hA5);
        write_reg(8'd2, 8'($urandom_range(0, 255)));
        write_reg(8'hFF, 8'($urandom_range(0, 255)));
        run_phase(270, 1'b0);
        write_reg(CFG_IDX_ESCAPE, 8'($urandom_range(0, 255)));
        write_reg(CFG_IDX_MASK, 8'($urandom_range(0, 255)));
        run_phase(270, 1'b1);
        write_reg(CFG_IDX_ESCAPE, ESCAPE_RESET);
        write_reg(CFG_IDX_MASK, MASK_RESET);
        run_phase(270, 1'b0);

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
